>>> sv/greatest_prime_factor_top_macros.svh
// assertion macros for the greatest prime factor block
// used by the checker bound to the top level; no other dependencies
`ifndef GREATEST_PRIME_FACTOR_TOP_MACROS_SVH
`define GREATEST_PRIME_FACTOR_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define GPF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define GPF_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> sv/gpf_pkg.sv
// shared types for the greatest prime factor block
// no dependencies; imported by the divider and the top level
`timescale 1ns / 1ps

package gpf_pkg;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_RESULT
  } gpf_state_t;

  // status from the serial divider to the sequencer
  typedef struct packed {
    logic done;      // quotient and remainder valid this cycle
    logic rem_zero;  // remainder is zero
  } gpf_div_stat_t;

endpackage

>>> sv/greatest_prime_factor_top.sv
// greatest prime factor by trial division, top level and sequencer
// depends on gpf_pkg and gpf_div
//
//   channel   handshake             payload
//   input     start, busy           number
//   result    done (one cycle)      factor, bad_input
//
// each trial division runs in the serial divider, one quotient bit per cycle;
// the number of trials grows with the second largest prime factor or with the
// square root of the largest, whichever is more.
// input 0 or 1 gives its result in the cycle right after acceptance.
// busy is high from acceptance until the result cycle ends; rst is synchronous.
// the result strobe cannot be held off by the receiver.
`timescale 1ns / 1ps

module greatest_prime_factor_top
  import gpf_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] number,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] factor,
  output logic                   bad_input
);

  localparam int W = VALUE_WIDTH;

  gpf_state_t     state, state_next;
  logic [W-1:0]   rest, rest_next;
  logic [W-1:0]   divisor, divisor_next;
  logic [W-1:0]   res, res_next;
  logic           bad, bad_next;

  logic           div_start;
  gpf_div_stat_t  div_stat;
  logic [W-1:0]   div_quo;

  gpf_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rest),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rest    <= rest_next;
    divisor <= divisor_next;
    res     <= res_next;
    bad     <= bad_next;
  end

  always_comb begin
    state_next   = state;
    rest_next    = rest;
    divisor_next = divisor;
    res_next     = res;
    bad_next     = bad;
    div_start    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          rest_next    = number;
          divisor_next = W'(2);
          bad_next     = 1'b0;
          if (number == '0) begin
            res_next   = '0;
            bad_next   = 1'b1;
            state_next = S_RESULT;
          end else if (number[W-1:1] == '0) begin
            // one has no prime factor: the search stops on the first divisor
            res_next   = W'(2);
            state_next = S_RESULT;
          end else begin
            state_next = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          if (div_quo < divisor) begin
            // divisor past the square root: what is left is prime
            res_next   = rest;
            state_next = S_RESULT;
          end else if (div_stat.rem_zero) begin
            rest_next  = div_quo;
            state_next = S_LAUNCH;
          end else begin
            divisor_next = divisor + 1'b1;
            state_next   = S_LAUNCH;
          end
        end
      end
      S_RESULT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_RESULT);
  assign factor    = res;
  assign bad_input = bad;

endmodule

>>> sv/gpf_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on gpf_pkg for the status struct
`timescale 1ns / 1ps

module gpf_div
  import gpf_pkg::*;
#(
  parameter int W = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output gpf_div_stat_t stat,
  output logic [W-1:0]  quotient
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic          done;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fit;

  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dvs};
    // no borrow means the divisor goes into the partial remainder
    fit   = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(W - 1);
    end else if (run) begin
      rem <= fit ? diff[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], fit};
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);
  assign quotient      = quo;

endmodule

>>> sv/gpf_checker.sv
// port-level checker for the greatest prime factor block
// depends on greatest_prime_factor_top_macros.svh; bound to the top level below
`timescale 1ns / 1ps
`include "greatest_prime_factor_top_macros.svh"

module gpf_checker #(
  parameter int VALUE_WIDTH = 31
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic [VALUE_WIDTH-1:0] number,
  input logic                   busy,
  input logic                   done,
  input logic [VALUE_WIDTH-1:0] factor,
  input logic                   bad_input
);

  localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(2);

  logic zero_take;

  assign zero_take = start && !busy && (number == '0);

  // a result only appears while an item is in hand
  `GPF_NEVER(a_done_idle, clk, rst, done && !busy, "result strobe while idle")

  // the block goes idle right after a result
  `GPF_ASSERT(a_idle_after, clk, rst, done |=> !busy, "still busy after result")

  // zero input is flagged on the very next cycle
  `GPF_ASSERT(a_zero_fast, clk, rst, zero_take |=> (done && bad_input), "zero input not flagged")

  // a flagged result carries no factor, a good one is at least two
  `GPF_NEVER(a_bad_factor, clk, rst, done && bad_input && factor != '0, "flagged with a factor")
  `GPF_NEVER(a_small_factor, clk, rst, done && !bad_input && factor < TWO, "factor below two")

endmodule

bind greatest_prime_factor_top gpf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_gpf_checker (.*);
